### hdl/rmtt_pkg.sv
// Package with shared types, constants and helper functions of the taint tracker.
`default_nettype none
package rmtt_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned LabelBits  = 32;
  localparam int unsigned NumTracked = 28;
  localparam int unsigned NumFam     = 6;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_MOVE  = 2'd2,
    OP_TAINT = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        two_operands;
    logic [4:0]  reg_operand;
    logic [4:0]  reg_dest;
    logic [63:0] mem_address;
  } taint_req_t;

  typedef struct packed {
    logic        address_hit;
    logic        reg_tainted_now;
    logic [31:0] label;
    logic        dropped;
  } taint_rsp_t;

  localparam logic [4:0] RegUntracked = 5'd28;
  localparam logic [4:0] RegNone      = 5'd29;
  localparam logic [2:0] FamNone      = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_UPDATE = 2'd2,
    ST_OUT    = 2'd3
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic show;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

  function automatic logic [2:0] family_of(input logic [4:0] code);
    logic [2:0] f;
    if (code < 5'd5) f = 3'd0;
    else if (code < 5'd10) f = 3'd1;
    else if (code < 5'd15) f = 3'd2;
    else if (code < 5'd20) f = 3'd3;
    else if (code < 5'd24) f = 3'd4;
    else if (code < 5'd28) f = 3'd5;
    else f = FamNone;
    return f;
  endfunction

  function automatic logic [4:0] family_last(input logic [2:0] f);
    logic [4:0] l;
    case (f)
      3'd0: l = 5'd4;
      3'd1: l = 5'd9;
      3'd2: l = 5'd14;
      3'd3: l = 5'd19;
      3'd4: l = 5'd23;
      default: l = 5'd27;
    endcase
    return l;
  endfunction

  function automatic logic [NumTracked-1:0] cascade_mask(input logic [4:0] code);
    logic [NumTracked-1:0] m;
    logic [2:0] f;
    logic [4:0] last;
    f = family_of(code);
    last = family_last(f);
    m = '0;
    for (int i = 0; i < NumTracked; i++) begin
      if (f != FamNone && 5'(i) >= code && 5'(i) <= last) m[i] = 1'b1;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

### hdl/rmtt_if.sv
// Valid-ready channel interface carrying a payload of parameterized type.
`default_nettype none
interface rmtt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/rmtt_ctrl.sv
// Controller state machine that sequences search, update and result delivery.
`default_nettype none
module rmtt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire rmtt_pkg::status_t status_i,
  output rmtt_pkg::cmd_t        cmd_o
);
  import rmtt_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.show = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_out_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> out_valid_o) else $error("result not shown after update");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
endmodule
`default_nettype wire

### hdl/rmtt_dp.sv
// Datapath holding register flags, labels, and the address table with its scan.
`default_nettype none
module rmtt_dp #(
  parameter int unsigned TABLE_DEPTH = rmtt_pkg::TableDepth,
  parameter int unsigned LABEL_BITS  = rmtt_pkg::LabelBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rmtt_pkg::cmd_t    cmd_i,
  output rmtt_pkg::status_t      status_o,
  input  wire logic [1:0]        op_i,
  input  wire logic              two_operands_i,
  input  wire logic [4:0]        reg_operand_i,
  input  wire logic [4:0]        reg_dest_i,
  input  wire logic [63:0]       mem_address_i,
  output logic                   address_hit_o,
  output logic                   reg_tainted_now_o,
  output logic [31:0]            label_o,
  output logic                   dropped_o
);
  import rmtt_pkg::*;
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic [63:0] mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;
  logic [NumTracked-1:0] flags_q;
  logic [LABEL_BITS-1:0] lab_q [NumFam];
  logic [LABEL_BITS-1:0] next_q;

  logic [1:0]  op_q;
  logic        two_q;
  logic [4:0]  rop_q, rdst_q;
  logic [63:0] addr_q;
  logic [IdxW:0] cnt_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic hit_q, free_q, rd_v_q;
  logic [63:0] rd_q;
  logic [IdxW-1:0] rd_idx_q;
  logic rd_vld_q;
  logic res_hit_q, res_taint, res_drop_q;
  logic [31:0] res_lab;

  logic [2:0] fam_r, fam_w, fam_a;
  logic [4:0] aff;
  logic [NumTracked-1:0] fl_n;
  logic [LABEL_BITS-1:0] nl_n;
  logic ins_ok, ins_try;
  logic [LABEL_BITS-1:0] lab_a;

  function automatic logic flags_of(input logic [4:0] c);
    return (c < 5'(NumTracked)) ? flags_q[c] : 1'b0;
  endfunction

  always_comb begin
    fam_r = family_of(rop_q);
    fam_w = family_of(rdst_q);
    ins_try = (op_q == OP_TAINT) ||
              (op_q == OP_STORE && two_q && flags_of(rop_q) && !hit_q);
    ins_ok = ins_try && !hit_q && free_q;
    aff = (op_q == OP_MOVE) ? ((rdst_q < RegNone) ? rdst_q : 5'd31)
        : (op_q == OP_TAINT) ? 5'd31 : rop_q;
    fam_a = family_of(aff);
    fl_n = flags_q;
    nl_n = next_q + LABEL_BITS'(1);
    if (nl_n == '0) nl_n = LABEL_BITS'(1);
  end

  // Sequential scan: one entry read per cycle, compared in the next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && cnt_q < (IdxW+1)'(TABLE_DEPTH)) begin
      rd_q <= mem_q[cnt_q[IdxW-1:0]];
      rd_idx_q <= cnt_q[IdxW-1:0];
      rd_vld_q <= vld_q[cnt_q[IdxW-1:0]];
    end
    if (cmd_i.update && ins_ok) begin
      mem_q[free_idx_q] <= addr_q;
    end
  end

  assign status_o.scan_done = cmd_i.scan && !rd_v_q && cnt_q == (IdxW+1)'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= op_i; two_q <= two_operands_i; rop_q <= reg_operand_i;
      rdst_q <= reg_dest_i; addr_q <= mem_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; flags_q <= '0; next_q <= LABEL_BITS'(1);
      for (int i = 0; i < NumFam; i++) lab_q[i] <= '0;
      cnt_q <= '0; rd_v_q <= 1'b0; hit_q <= 1'b0; free_q <= 1'b0;
      hit_idx_q <= '0; free_idx_q <= '0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0; rd_v_q <= 1'b0; hit_q <= 1'b0; free_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        rd_v_q <= cnt_q < (IdxW+1)'(TABLE_DEPTH);
        if (cnt_q < (IdxW+1)'(TABLE_DEPTH)) cnt_q <= cnt_q + (IdxW+1)'(1);
        if (rd_v_q) begin
          if (rd_vld_q && rd_q == addr_q && !hit_q) begin
            hit_q <= 1'b1; hit_idx_q <= rd_idx_q;
          end
          if (!rd_vld_q && !free_q) begin
            free_q <= 1'b1; free_idx_q <= rd_idx_q;
          end
        end
      end
      if (cmd_i.update) begin
        case (op_q)
          OP_LOAD: if (two_q && hit_q) begin
            flags_q <= fl_n | cascade_mask(rop_q);
            if (fam_r != FamNone) lab_q[fam_r] <= next_q;
            next_q <= nl_n;
          end
          OP_STORE: if (two_q) begin
            if (!flags_of(rop_q) && hit_q) vld_q[hit_idx_q] <= 1'b0;
            else if (ins_ok) vld_q[free_idx_q] <= 1'b1;
          end
          OP_MOVE: if (two_q && rdst_q < RegNone) begin
            if (flags_of(rdst_q) && !flags_of(rop_q)) begin
              flags_q <= fl_n & ~cascade_mask(rdst_q);
              if (fam_w != FamNone) lab_q[fam_w] <= '0;
            end else if (flags_of(rop_q)) begin
              if (!flags_of(rdst_q)) flags_q <= fl_n | cascade_mask(rdst_q);
              if (fam_w != FamNone)
                lab_q[fam_w] <= (fam_r != FamNone) ? lab_q[fam_r] : '0;
            end
          end
          default: if (ins_ok) vld_q[free_idx_q] <= 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_hit_q <= (op_q == OP_MOVE) ? 1'b0 : hit_q;
      res_drop_q <= ins_try && !hit_q && !free_q;
    end
  end

  always_comb begin
    lab_a = (fam_a != FamNone) ? lab_q[fam_a] : '0;
    res_taint = flags_of(aff);
    res_lab = res_taint || fam_a != FamNone ? 32'(lab_a) : 32'd0;
  end

  assign address_hit_o = res_hit_q;
  assign reg_tainted_now_o = res_taint;
  assign label_o = res_lab;
  assign dropped_o = res_drop_q;

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && hit_q) |-> vld_q[hit_idx_q]) else $error("hit on invalid entry");
  a_free_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && free_q) |-> !vld_q[free_idx_q]) else $error("free slot is valid");
  a_label_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q != '0) else $error("label counter zero");
endmodule
`default_nettype wire

### hdl/register_memory_taint_tracker.sv
// Top level of the register and memory taint tracker.
// Each transaction is accepted in idle, then scans the address table, updates state and shows its result.
// The address table is scanned one entry per cycle through one memory read port.
// One transaction is in flight at a time; a new one is accepted only after the result is taken.
// Reset clears flags, labels and valid bits at once and sets the label counter to one.
`default_nettype none
module register_memory_taint_tracker #(
  parameter int unsigned TABLE_DEPTH = rmtt_pkg::TableDepth,
  parameter int unsigned LABEL_BITS  = rmtt_pkg::LabelBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rmtt_if.sink     in_i,
  rmtt_if.source   out_o
);
  import rmtt_pkg::*;
  cmd_t cmd;
  status_t status;
  logic out_valid;

  rmtt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_valid), .out_ready_i(out_o.ready),
    .status_i(status), .cmd_o(cmd)
  );
  assign out_o.valid = out_valid;

  rmtt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .LABEL_BITS(LABEL_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .op_i(in_i.data.op), .two_operands_i(in_i.data.two_operands),
    .reg_operand_i(in_i.data.reg_operand), .reg_dest_i(in_i.data.reg_dest),
    .mem_address_i(in_i.data.mem_address),
    .address_hit_o(out_o.data.address_hit),
    .reg_tainted_now_o(out_o.data.reg_tainted_now),
    .label_o(out_o.data.label), .dropped_o(out_o.data.dropped)
  );
endmodule
`default_nettype wire
